@@ rtl/hdh_pkg.sv @@
// Package for the Hamming distance histogram: sizes, field widths, codes and
// state machine type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdh_pkg;

   localparam int BUCKET_BITS = 10;
   localparam int MAX_DIST    = 10;

   localparam int KEY_W  = 10;
   localparam int CNT_W  = 32;
   localparam int TOT_W  = 48;
   localparam int DIST_W = 5;
   localparam int CSR_W  = 4;

   localparam int ROWS   = 1 << BUCKET_BITS;
   localparam int ROW_AW = BUCKET_BITS;
   localparam int IDX_W  = BUCKET_BITS + 1;
   localparam int ROW_W  = MAX_DIST * CNT_W;
   localparam int PC_W   = $clog2(BUCKET_BITS + 1);

   localparam logic [CNT_W-1:0] OUT_OF_RANGE_COUNT = 32'd134217728;
   localparam logic [CSR_W-1:0] CSR_RESET          = 4'd10;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_QUERY  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INSERT,
      ST_QUERY
   } state_type;

endpackage

`default_nettype wire

@@ rtl/hdh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/hamming_distance_histogram.sv @@
// Hamming distance histogram: a row-wide count RAM (one row per bucket, one
// 32-bit column per distance) swept by one read-modify-write adder.
// Insert: one RAM row per bucket, read/write overlapped.
// Query: one registered RAM read, then a registered result strobe.
// Reset and every csr write start a clearing pass, one row a cycle, with
// busy high. The receiver cannot stall results.
// Depends on hdh_pkg and hdh_ram.
`timescale 1ns / 1ps
`default_nettype none

module hamming_distance_histogram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_type,
   input  wire logic [hdh_pkg::KEY_W-1:0]   req_key,
   input  wire logic [hdh_pkg::CNT_W-1:0]   req_add_count,
   input  wire logic [hdh_pkg::DIST_W-1:0]  req_distance,
   output logic                             rsp_valid,
   output logic      [hdh_pkg::CNT_W-1:0]   rsp_result_count,
   output logic      [hdh_pkg::TOT_W-1:0]   rsp_total_count,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [hdh_pkg::CSR_W-1:0]   csr_bucket_bits
);

   import hdh_pkg::*;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [ROW_AW-1:0]  pend_row_ff, pend_row_in;
   logic [ROW_AW-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]   add_ff, add_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [CSR_W-1:0]   bucket_bits_ff, bucket_bits_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   rsp_result_ff, rsp_result_in;
   logic [TOT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic [CSR_W-1:0]   b_act;
   logic [PC_W-1:0]    lim;
   logic [ROW_AW-1:0]  row_mask;
   logic [IDX_W-1:0]   n_buckets;
   logic [ROW_AW-1:0]  diff;
   logic [PC_W-1:0]    pc;
   logic [CNT_W-1:0]   old_col;
   logic [CNT_W-1:0]   new_col;
   logic [ROW_W-1:0]   row_upd;
   logic [CNT_W-1:0]   q_col;
   logic               issue;

   logic               ram_wr_en;
   logic [ROW_AW-1:0]  ram_wr_addr;
   logic [ROW_W-1:0]   ram_wr_data;
   logic               ram_rd_en;
   logic [ROW_AW-1:0]  ram_rd_addr;
   logic [ROW_W-1:0]   ram_rd_data;

   hdh_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Active bits, distance limit, key mask and bucket count.
   always_comb begin
      if (int'(bucket_bits_ff) > BUCKET_BITS) begin
         b_act = CSR_W'(BUCKET_BITS);
      end else begin
         b_act = bucket_bits_ff;
      end
      if (int'(b_act) < MAX_DIST) begin
         lim = PC_W'(b_act);
      end else begin
         lim = PC_W'(MAX_DIST);
      end
      for (int j = 0; j < ROW_AW; j++) begin
         row_mask[j] = (j < int'(b_act));
      end
      n_buckets = IDX_W'(1) << b_act;
   end

   // Distance of the row coming back from the RAM, its updated contents and the queried column.
   always_comb begin
      diff = (key_ff ^ pend_row_ff) & row_mask;
      pc   = '0;
      for (int j = 0; j < ROW_AW; j++) begin
         pc = pc + PC_W'(diff[j]);
      end
      old_col = '0;
      for (int c = 0; c < MAX_DIST; c++) begin
         if (int'(pc) == c) begin
            old_col = ram_rd_data[c*CNT_W +: CNT_W];
         end
      end
      new_col = old_col + add_ff;
      for (int c = 0; c < MAX_DIST; c++) begin
         if (int'(pc) == c) begin
            row_upd[c*CNT_W +: CNT_W] = new_col;
         end else begin
            row_upd[c*CNT_W +: CNT_W] = ram_rd_data[c*CNT_W +: CNT_W];
         end
      end
      q_col = '0;
      for (int c = 0; c < MAX_DIST; c++) begin
         if (int'(dist_ff[DIST_W-2:0]) == c) begin
            q_col = ram_rd_data[c*CNT_W +: CNT_W];
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pend_in        = pend_ff;
      pend_row_in    = pend_row_ff;
      key_in         = key_ff;
      add_in         = add_ff;
      dist_in        = dist_ff;
      total_in       = total_ff;
      bucket_bits_in = bucket_bits_ff;
      rsp_valid_in   = 1'b0;
      rsp_result_in  = rsp_result_ff;
      rsp_total_in   = rsp_total_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pend_row_ff;
      ram_wr_data    = row_upd;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = cnt_ff[ROW_AW-1:0];
      issue          = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff[ROW_AW-1:0];
            ram_wr_data = '0;
            cnt_in      = cnt_ff + IDX_W'(1);
            if (cnt_ff == IDX_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               key_in  = ROW_AW'(req_key) & row_mask;
               add_in  = req_add_count;
               dist_in = req_distance;
               if (req_kind_type'(req_type) == REQ_INSERT) begin
                  total_in = total_ff + TOT_W'(req_add_count);
                  cnt_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_INSERT;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = ROW_AW'(req_key) & row_mask;
                  state_in    = ST_QUERY;
               end
            end
         end
         ST_INSERT: begin
            // read row cnt while writing back the row read in the previous cycle
            issue = (cnt_ff < n_buckets);
            if (issue) begin
               ram_rd_en = 1'b1;
               cnt_in    = cnt_ff + IDX_W'(1);
            end
            pend_in     = issue;
            pend_row_in = cnt_ff[ROW_AW-1:0];
            if (pend_ff && (pc < lim)) begin
               ram_wr_en = 1'b1;
            end
            if (!issue && !pend_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = '0;
               rsp_total_in  = total_ff;
               state_in      = ST_IDLE;
            end
         end
         ST_QUERY: begin
            if (dist_ff[DIST_W-1]) begin
               rsp_result_in = '0;
            end else if (int'(dist_ff[DIST_W-2:0]) >= int'(lim)) begin
               rsp_result_in = OUT_OF_RANGE_COUNT;
            end else begin
               rsp_result_in = q_col;
            end
            rsp_valid_in = 1'b1;
            rsp_total_in = total_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a register write re-initializes the table and the total
      if (csr_valid) begin
         bucket_bits_in = csr_bucket_bits;
         total_in       = '0;
         cnt_in         = '0;
         state_in       = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         cnt_ff         <= '0;
         pend_ff        <= 1'b0;
         total_ff       <= '0;
         bucket_bits_ff <= CSR_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         pend_ff        <= pend_in;
         total_ff       <= total_in;
         bucket_bits_ff <= bucket_bits_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff   <= pend_row_in;
      key_ff        <= key_in;
      add_ff        <= add_in;
      dist_ff       <= dist_in;
      rsp_result_ff <= rsp_result_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_count = rsp_result_ff;
   assign rsp_total_count  = rsp_total_ff;

endmodule

`default_nettype wire
